// ===== sv/rrd_pkg.sv =====
`default_nettype none
package rrd_pkg;

    // frame layout
    localparam int BodyLen = 6;
    localparam int IdxW    = $clog2(BodyLen);

    // configuration register indexes
    localparam logic [7:0] REG_FRAME_HEADER = 8'd0;
    localparam logic [7:0] REG_DEVICE_CODE  = 8'd1;

    // response codes carried in body byte 0
    localparam logic [7:0] CODE_SELF_CHECK = 8'h01;
    localparam logic [7:0] CODE_RANGE_A    = 8'h02;
    localparam logic [7:0] CODE_RANGE_B    = 8'h04;
    localparam logic [7:0] CODE_RANGE_C    = 8'h0B;
    localparam logic [7:0] CODE_RANGE_D    = 8'h0C;
    localparam logic [7:0] CODE_PULSE      = 8'h0A;
    localparam logic [7:0] CODE_PRODUCT    = 8'h10;
    localparam logic [7:0] CODE_TEMP       = 8'h06;
    localparam logic [7:0] STATUS_FAULT    = 8'h01;

    // result kinds
    localparam logic [2:0] KIND_SELF_CHECK = 3'd0;
    localparam logic [2:0] KIND_RANGING    = 3'd1;
    localparam logic [2:0] KIND_PULSE      = 3'd2;
    localparam logic [2:0] KIND_PRODUCT    = 3'd3;
    localparam logic [2:0] KIND_TEMP       = 3'd4;
    localparam logic [2:0] KIND_CSUM_ERR   = 3'd5;

    localparam logic [22:0] LASER_SCALE = 23'd100;

    // framer to decoder: a completed frame
    typedef struct packed {
        logic                    done;
        logic                    sum_ok;
        logic [BodyLen-1:0][7:0] body;
    } frame_t;

    // framer status toward the top level
    typedef struct packed {
        logic phase_sum;
    } framer_stat_t;

    typedef struct packed {
        logic [2:0]         response_kind;
        logic [7:0]         raw_status;
        logic [3:0]         status_flags;
        logic [15:0]        distance;
        logic               range_valid;
        logic [7:0]         pulse_count;
        logic [22:0]        laser_count;
        logic signed [7:0]  temperature;
        logic [7:0]         product_id;
        logic [3:0]         version_major;
        logic [3:0]         version_minor;
    } result_t;

endpackage
`default_nettype wire

// ===== sv/rrd_if.sv =====
`default_nettype none

// received byte channel
interface rrd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded response channel
interface rrd_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         response_kind;
    logic [7:0]         raw_status;
    logic [3:0]         status_flags;
    logic [15:0]        distance;
    logic               range_valid;
    logic [7:0]         pulse_count;
    logic [22:0]        laser_count;
    logic signed [7:0]  temperature;
    logic [7:0]         product_id;
    logic [3:0]         version_major;
    logic [3:0]         version_minor;
    modport source (output valid, output response_kind, output raw_status,
                    output status_flags, output distance, output range_valid,
                    output pulse_count, output laser_count, output temperature,
                    output product_id, output version_major, output version_minor,
                    input ready);
    modport sink   (input valid, input response_kind, input raw_status,
                    input status_flags, input distance, input range_valid,
                    input pulse_count, input laser_count, input temperature,
                    input product_id, input version_major, input version_minor,
                    output ready);
endinterface

// register write channel
interface rrd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rrd_framer.sv =====
`default_nettype none
module rrd_framer
    import rrd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rrd_cfg_if.sink      cfg,
    input  wire logic    beat,
    input  wire logic [7:0] rx_byte,
    output frame_t       frame,
    output framer_stat_t stat
);

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_HDR,
        PH_BODY,
        PH_SUM
    } phase_t;

    phase_t          phase_reg;
    logic [IdxW-1:0] idx_reg;
    logic [7:0]      sum_reg;
    logic [7:0]      header_reg;
    logic [7:0]      device_reg;
    logic [7:0]      store_reg [BodyLen];

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            device_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_FRAME_HEADER)
                header_reg <= cfg.data;
            else if (cfg.index == REG_DEVICE_CODE)
                device_reg <= cfg.data;
        end
    end

    // hunt and collect state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (beat)
        begin
            unique case (phase_reg)
                PH_SEEK:
                begin
                    if (rx_byte == header_reg)
                        phase_reg <= PH_HDR;
                end
                PH_HDR:
                begin
                    // device check first; a repeated header keeps the hunt armed
                    if (rx_byte == device_reg)
                    begin
                        phase_reg <= PH_BODY;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                    end
                    else if (rx_byte != header_reg)
                        phase_reg <= PH_SEEK;
                end
                PH_BODY:
                begin
                    sum_reg <= sum_reg + rx_byte;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IdxW'(BodyLen - 1))
                        phase_reg <= PH_SUM;
                end
                PH_SUM:
                begin
                    phase_reg <= PH_SEEK;
                    idx_reg   <= '0;
                    sum_reg   <= '0;
                end
                default: phase_reg <= PH_SEEK;
            endcase
        end
    end

    // body bytes, no reset
    always_ff @(posedge clk)
    begin
        if (beat && phase_reg == PH_BODY)
            store_reg[idx_reg] <= rx_byte;
    end

    always_comb
    begin
        frame.done   = beat && (phase_reg == PH_SUM);
        frame.sum_ok = (rx_byte == sum_reg);
        for (int i = 0; i < BodyLen; i++)
            frame.body[i] = store_reg[i];
    end

    assign stat.phase_sum = (phase_reg == PH_SUM);

endmodule
`default_nettype wire

// ===== sv/rrd_decoder.sv =====
`default_nettype none
module rrd_decoder
    import rrd_pkg::*;
(
    input  frame_t  frame,
    output logic    has_result,
    output result_t result
);

    logic [7:0]  st;
    logic        fault;
    logic [15:0] base;
    logic [6:0]  mag;

    function automatic logic [3:0] flags(input logic [7:0] s, input logic f);
        flags = {s[5], s[4], s[3], f};
    endfunction

    always_comb
    begin
        result     = '0;
        has_result = 1'b0;
        st         = frame.body[1];
        fault      = (st == STATUS_FAULT);
        base       = {frame.body[4], frame.body[3]};
        mag        = frame.body[2][6:0];
        if (!frame.sum_ok)
        begin
            has_result           = 1'b1;
            result.response_kind = KIND_CSUM_ERR;
        end
        else
        begin
            unique case (frame.body[0])
                CODE_SELF_CHECK:
                begin
                    has_result           = 1'b1;
                    result.response_kind = KIND_SELF_CHECK;
                    result.raw_status    = frame.body[2];
                    result.status_flags  = flags(frame.body[2],
                                                 frame.body[1] == STATUS_FAULT);
                end
                CODE_RANGE_A, CODE_RANGE_B, CODE_RANGE_C, CODE_RANGE_D:
                begin
                    has_result           = 1'b1;
                    result.response_kind = KIND_RANGING;
                    result.raw_status    = st;
                    result.status_flags  = flags(st, fault);
                    result.distance      = {frame.body[3], frame.body[4]};
                    result.range_valid   = ({frame.body[3], frame.body[4]} != 16'd0)
                                           && !st[3] && !fault;
                    result.pulse_count   = frame.body[5];
                end
                CODE_PULSE:
                begin
                    has_result           = 1'b1;
                    result.response_kind = KIND_PULSE;
                    result.laser_count   = 23'(base) * LASER_SCALE;
                end
                CODE_PRODUCT:
                begin
                    has_result           = 1'b1;
                    result.response_kind = KIND_PRODUCT;
                    result.product_id    = frame.body[1];
                    result.version_major = frame.body[2][7:4];
                    result.version_minor = frame.body[2][3:0];
                end
                CODE_TEMP:
                begin
                    has_result           = 1'b1;
                    result.response_kind = KIND_TEMP;
                    // sign-magnitude to two's complement
                    result.temperature   = frame.body[2][7] ? -$signed({1'b0, mag})
                                                            : $signed({1'b0, mag});
                end
                default: has_result = 1'b0;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/rangefinder_response_deframer_unit.sv =====
`default_nettype none
// Channel  Dir  Beat contents
// rx       in   rx_byte, one received serial byte
// res      out  decoded response fields or checksum error
// cfg      in   index, data: register write (0 header, 1 device code)
//
// One byte per cycle. A byte is taken every cycle unless it is a checksum
// byte and a previous response still sits unread in the output register.
// The result of a checksum byte is registered and appears in the cycle after its beat.
// Reset is asynchronous, active low; it clears the hunt state, the configuration registers and the output valid flag.
module rangefinder_response_deframer_unit
    import rrd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rrd_byte_if.sink     rx,
    rrd_result_if.source res,
    rrd_cfg_if.sink      cfg
);

    frame_t       frame;
    framer_stat_t stat;
    logic         has_result;
    result_t      result;
    logic         beat;
    logic         out_valid_reg;
    result_t      res_reg;

    // only a checksum byte needs room in the output register
    assign rx.ready = !out_valid_reg || res.ready || !stat.phase_sum;
    assign beat     = rx.valid && rx.ready;

    rrd_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .beat    (beat),
        .rx_byte (rx.rx_byte),
        .frame   (frame),
        .stat    (stat)
    );

    rrd_decoder u_decoder (
        .frame      (frame),
        .has_result (has_result),
        .result     (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (frame.done && has_result)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame.done && has_result)
            res_reg <= result;
    end

    assign res.valid         = out_valid_reg;
    assign res.response_kind = res_reg.response_kind;
    assign res.raw_status    = res_reg.raw_status;
    assign res.status_flags  = res_reg.status_flags;
    assign res.distance      = res_reg.distance;
    assign res.range_valid   = res_reg.range_valid;
    assign res.pulse_count   = res_reg.pulse_count;
    assign res.laser_count   = res_reg.laser_count;
    assign res.temperature   = res_reg.temperature;
    assign res.product_id    = res_reg.product_id;
    assign res.version_major = res_reg.version_major;
    assign res.version_minor = res_reg.version_minor;

endmodule
`default_nettype wire
